### rtl/fcf_pkg.sv
// shared constants and controller/datapath interface types for the fir convolution filter
package fcf_pkg;

    localparam int DEFAULT_MAX_TAPS = 1024;

    localparam int CMD_W       = 1;
    localparam int TAP_INDEX_W = 10;
    localparam int SAMPLE_W    = 16;
    localparam int TAP_COUNT_W = 11;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = 40;
    localparam int FRAC_BITS   = 15;

    localparam logic [CMD_W-1:0]       CMD_LOAD_TAP    = 1'b0;
    localparam logic [CMD_W-1:0]       CMD_SAMPLE      = 1'b1;
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic tap_write;
        logic sample_start;
        logic clear_step;
        logic mac_issue;
        logic out_load;
    } fcf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic issue_last;
        logic pipe_idle;
        logic out_free;
    } fcf_status_t;

endpackage

### rtl/fcf_ram.sv
// generic simple dual-port ram with registered read
module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/fcf_ctrl.sv
// controller state machine: clearing pass, request intake, mac sweep, drain and result hand-off
module fcf_ctrl import fcf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  fcf_status_t      dp_status,
    output fcf_cmd_t         dp_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next          = state_reg;
        dp_cmd              = '0;
        dp_cmd.tap_write    = accept && (cmd == CMD_LOAD_TAP);
        dp_cmd.sample_start = accept && (cmd == CMD_SAMPLE);
        case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clear_step = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (dp_cmd.sample_start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                dp_cmd.mac_issue = 1'b1;
                if (dp_status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dp_status.pipe_idle)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // no request is taken until the clearing pass has swept every entry
    a_clear_before_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && $past(state_reg == ST_CLEAR) |-> $past(dp_status.clear_last))
        else $error("intake opened before clearing pass finished");

    // result is only loaded once the mac pipeline has drained
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> $past(state_reg == ST_DRAIN) || $past(state_reg == ST_FINISH))
        else $error("result loaded without drain");

    // a sample request always leads straight into the mac sweep
    a_sample_runs: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.sample_start |=> state_reg == ST_RUN)
        else $error("sample request did not start the mac sweep");

endmodule

### rtl/fcf_datapath.sv
// datapath: tap and history rams, circular cursor, shared mac, rounding and output register
module fcf_datapath import fcf_pkg::*; #(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS,
    localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [TAP_COUNT_W-1:0]     cfg_wdata,
    input  logic [TAP_INDEX_W-1:0]     tap_index,
    input  logic signed [SAMPLE_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] filtered_sample,
    input  fcf_cmd_t                   dp_cmd,
    output fcf_status_t                dp_status
);

    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [AW-1:0]          wpos_reg;
    logic [AW-1:0]          wpos_next;
    logic [AW-1:0]          k_reg;
    logic [AW-1:0]          k_next;
    logic [AW-1:0]          pos_reg;
    logic [AW-1:0]          pos_next;
    logic [AW-1:0]          last_reg;
    logic [AW-1:0]          last_eff;
    logic [AW-1:0]          start_pos;
    logic                   rd_v_reg;
    logic                   mul_v_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic signed [SAMPLE_W-1:0] coef_q;
    logic signed [SAMPLE_W-1:0] hist_q;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic signed [ACC_W:0]      rounded;
    logic signed [ACC_W-FRAC_BITS:0] shifted;
    logic signed [SAMPLE_W-1:0] sat_value;
    logic signed [SAMPLE_W-1:0] filtered_sample_reg;

    logic                   coef_we;
    logic [AW-1:0]          coef_waddr;
    logic [SAMPLE_W-1:0]    coef_wdata;
    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic [SAMPLE_W-1:0]    hist_wdata;

    // effective last tap index from the tap count register
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            last_eff = '0;
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            last_eff = AW'(MAX_TAPS - 1);
        end
        else
        begin
            last_eff = AW'(tap_count_reg - 11'd1);
        end
    end

    assign start_pos = (wpos_reg > last_eff) ? '0 : wpos_reg;

    // ram write ports
    assign coef_we    = dp_cmd.clear_step || (dp_cmd.tap_write && (32'(tap_index) < MAX_TAPS));
    assign coef_waddr = dp_cmd.clear_step ? k_reg : AW'(tap_index);
    assign coef_wdata = dp_cmd.clear_step ? '0 : value;
    assign hist_we    = dp_cmd.clear_step || dp_cmd.sample_start;
    assign hist_waddr = dp_cmd.clear_step ? k_reg : start_pos;
    assign hist_wdata = dp_cmd.clear_step ? '0 : value;

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (k_reg),
        .rdata (coef_q)
    );

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (pos_reg),
        .rdata (hist_q)
    );

    // counters and cursor
    always_comb
    begin
        k_next    = k_reg;
        pos_next  = pos_reg;
        wpos_next = wpos_reg;
        if (dp_cmd.sample_start)
        begin
            k_next    = '0;
            pos_next  = start_pos;
            wpos_next = (start_pos == '0) ? last_eff : start_pos - 1'b1;
        end
        else if (dp_cmd.clear_step || dp_cmd.mac_issue)
        begin
            k_next = k_reg + 1'b1;
            if (dp_cmd.mac_issue)
            begin
                pos_next = (pos_reg == last_reg) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    // accumulator wraps modulo 2^40
    always_comb
    begin
        acc_next = acc_reg;
        if (dp_cmd.sample_start)
        begin
            acc_next = '0;
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up then saturate
    always_comb
    begin
        rounded = $signed({acc_reg[ACC_W-1], acc_reg})
                  + $signed((ACC_W+1)'(1 << (FRAC_BITS - 1)));
        shifted = rounded[ACC_W:FRAC_BITS];
        if (shifted > $signed((ACC_W-FRAC_BITS+1)'(32767)))
        begin
            sat_value = 16'sh7fff;
        end
        else if (shifted < -$signed((ACC_W-FRAC_BITS+1)'(32768)))
        begin
            sat_value = -16'sh8000;
        end
        else
        begin
            sat_value = shifted[SAMPLE_W-1:0];
        end
    end

    assign out_valid_next = dp_cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            wpos_reg      <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            last_reg      <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (dp_cmd.sample_start)
            begin
                last_reg <= last_eff;
            end
            wpos_reg      <= wpos_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            rd_v_reg      <= dp_cmd.mac_issue;
            mul_v_reg     <= rd_v_reg;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_q * hist_q;
        if (dp_cmd.out_load)
        begin
            filtered_sample_reg <= sat_value;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = filtered_sample_reg;

    assign dp_status.clear_last = (k_reg == AW'(MAX_TAPS - 1));
    assign dp_status.issue_last = (k_reg == last_reg);
    assign dp_status.pipe_idle  = !rd_v_reg && !mul_v_reg;
    assign dp_status.out_free   = !out_valid_reg || out_ready;

    a_out_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");

    a_start_with_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.sample_start |-> !rd_v_reg && !mul_v_reg && !dp_cmd.mac_issue)
        else $error("sample started with mac pipeline busy");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.mac_issue |-> pos_reg <= last_reg && k_reg <= last_reg)
        else $error("mac cursor beyond tap count");

    a_mul_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        mul_v_reg |-> $past(dp_cmd.mac_issue, 2))
        else $error("product stage without a read two cycles earlier");

endmodule

### rtl/fir_convolution_filter_top.sv
// top level of the direct-form fir convolution filter with circular history
//
//  channel   direction  handshake            payload
//  in        request    in_valid/in_ready    cmd, tap_index, value
//  out       result     out_valid/out_ready  filtered_sample
//  cfg       write      cfg_wen              cfg_wdata (tap_count)
//
//  after reset a clearing pass zeroes every entry of both rams, with in_ready low
//  a tap load request gives no result and leaves intake open for the next request
//  a sample runs N macs, N the effective tap count, then a drain, before its result and the
//  next intake: one mac per cycle, set by the single read port of each ram and the multiplier
//  the result sits in an output register; a tap load is taken while it waits,
//  the next sample holds at its last step until that register is free
module fir_convolution_filter_top import fcf_pkg::*; #(
    parameter int MAX_TAPS = DEFAULT_MAX_TAPS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [TAP_COUNT_W-1:0]     cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           cmd,
    input  logic [TAP_INDEX_W-1:0]     tap_index,
    input  logic signed [SAMPLE_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] filtered_sample
);

    fcf_cmd_t    dp_cmd;
    fcf_status_t dp_status;

    fcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    fcf_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .tap_index       (tap_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status)
    );

endmodule

### tb/fir_convolution_filter_top_tb.sv
// self-checking testbench for the fir convolution filter top level
`timescale 1ns / 1ps

module fir_convolution_filter_top_tb import fcf_pkg::*;;

    localparam int MAX_TAPS      = DEFAULT_MAX_TAPS;
    localparam int TOTAL_REQS    = 580;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int IDLE_PERCENT  = 38;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CMD_W-1:0]           cmd;
        logic [TAP_INDEX_W-1:0]     tap_index;
        logic signed [SAMPLE_W-1:0] value;
        logic [TAP_COUNT_W-1:0]     tap_cnt;
        logic                       use_lit;
        logic signed [SAMPLE_W-1:0] lit;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sd32767, 11'd0,    1'b1, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd1023,  16'sh8000,  11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd0,     16'sh8000,  11'd0,    1'b0, 16'sd0},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd1,    1'b0, 16'sd0},
        // stale position after lowering the tap count, positive saturation
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sh8000,  11'd0,    1'b1, 16'sd32767},
        '{ROW_REQ, CMD_SAMPLE,   10'd1023,  16'sd32767, 11'd0,    1'b1, -16'sd32767},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sd1,     11'd0,    1'b1, -16'sd1},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd0,     16'sd16384, 11'd0,    1'b0, 16'sd0},
        // halves round up
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sd1,     11'd0,    1'b1, 16'sd1},
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     -16'sd1,    11'd0,    1'b1, 16'sd0},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd2047, 1'b0, 16'sd0},
        '{ROW_REQ, CMD_SAMPLE,   10'h2aa,   16'sd32767, 11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd1,     16'sd12345, 11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd2,     -16'sd20000, 11'd0,   1'b0, 16'sd0},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd2,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd0,     16'sh8000,  11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_LOAD_TAP, 10'd1,     16'sh8000,  11'd0,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_SAMPLE,   10'h155,   16'sd32767, 11'd0,    1'b0, 16'sd0},
        // negative saturation
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sd32767, 11'd0,    1'b1, 16'sh8000},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd3,    1'b0, 16'sd0},
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sh8000,  11'd0,    1'b0, 16'sd0},
        '{ROW_CFG, CMD_SAMPLE,   10'd0,     16'sd0,     11'd1024, 1'b0, 16'sd0},
        '{ROW_REQ, CMD_SAMPLE,   10'd0,     16'sd0,     11'd0,    1'b0, 16'sd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wen = 1'b0;
    logic [TAP_COUNT_W-1:0]     cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [CMD_W-1:0]           cmd = CMD_LOAD_TAP;
    logic [TAP_INDEX_W-1:0]     tap_index = '0;
    logic signed [SAMPLE_W-1:0] value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered_sample;

    logic signed [SAMPLE_W-1:0] tap_coef [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] sample_hist [MAX_TAPS];
    int unsigned                newest_slot;
    logic [TAP_COUNT_W-1:0]     tap_count_set;

    logic signed [SAMPLE_W-1:0] pending_outputs [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         error_count = 0;
    int                         reqs_sent = 0;
    int                         quiet_cycles;
    int                         hold_left = 0;
    logic                       hold_done = 1'b0;
    logic                       hold_req = 1'b0;
    logic                       steady = 1'b0;

    fir_convolution_filter_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .tap_index       (tap_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned active_taps(input logic [TAP_COUNT_W-1:0] count);
        if (count == 0)
            return 1;
        if (count > MAX_TAPS)
            return MAX_TAPS;
        return 32'(count);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        int unsigned              taps;
        int unsigned              slot;
        int unsigned              rd;
        logic signed [PROD_W-1:0] prod;
        logic signed [ACC_W-1:0]  acc;
        longint                   y;
        taps = active_taps(tap_count_set);
        slot = (newest_slot >= taps) ? 0 : newest_slot;
        sample_hist[slot] = x;
        acc = '0;
        rd = slot;
        for (int k = 0; k < taps; k++)
        begin
            prod = tap_coef[k] * sample_hist[rd];
            acc = acc + ACC_W'(prod);
            rd = (rd + 1 >= taps) ? 0 : rd + 1;
        end
        y = longint'(acc);
        y = (y + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        newest_slot = (slot == 0) ? taps - 1 : slot - 1;
        return SAMPLE_W'(y);
    endfunction

    task automatic send_request(
        input logic [CMD_W-1:0]           req_cmd,
        input logic [TAP_INDEX_W-1:0]     req_idx,
        input logic signed [SAMPLE_W-1:0] req_val,
        input logic                       use_lit,
        input logic signed [SAMPLE_W-1:0] lit
    );
        logic signed [SAMPLE_W-1:0] got;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        cmd       <= req_cmd;
        tap_index <= req_idx;
        value     <= req_val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (req_cmd == CMD_LOAD_TAP)
            tap_coef[req_idx] = req_val;
        else
        begin
            got = filter_sample(req_val);
            pending_outputs.push_back(use_lit ? lit : got);
        end
        reqs_sent++;
    endtask

    task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] count);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_wen <= 1'b0;
        tap_count_set = count;
    endtask

    initial
    begin : stimulus
        int unsigned               pick;
        int unsigned               eff;
        int unsigned               phase_len;
        logic [TAP_COUNT_W-1:0]    new_count;
        logic [TAP_INDEX_W-1:0]    idx;
        logic signed [SAMPLE_W-1:0] v;
        logic                      is_tap;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            tap_coef[i]    = '0;
            sample_hist[i] = '0;
        end
        newest_slot   = 0;
        tap_count_set = TAP_COUNT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                set_tap_count(DIRECTED[r].tap_cnt);
            else
                send_request(DIRECTED[r].cmd, DIRECTED[r].tap_index, DIRECTED[r].value,
                             DIRECTED[r].use_lit, DIRECTED[r].lit);
        end

        while (reqs_sent < TOTAL_REQS)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                new_count = '0;
            else if (pick < 10)
                new_count = TAP_COUNT_W'($urandom_range(MAX_TAPS + 1, 2047));
            else if (pick < 14)
                new_count = TAP_COUNT_W'(MAX_TAPS);
            else if (pick < 20)
                new_count = TAP_COUNT_W'(1);
            else if (pick < 30)
                new_count = TAP_COUNT_W'($urandom_range(49, 300));
            else
                new_count = TAP_COUNT_W'($urandom_range(2, 48));
            set_tap_count(new_count);
            eff = active_taps(new_count);
            phase_len = (eff > 300) ? $urandom_range(3, 6) : $urandom_range(15, 45);
            for (int i = 0; i < phase_len; i++)
            begin
                steady <= (reqs_sent >= 300 && reqs_sent < 380);
                if (reqs_sent == 450)
                    hold_req <= 1'b1;
                is_tap = ($urandom_range(99) < 35);
                if ($urandom_range(99) < 15)
                begin
                    case ($urandom_range(4))
                        0: v = 16'sh8000;
                        1: v = 16'sd32767;
                        2: v = 16'sd0;
                        3: v = -16'sd1;
                        default: v = 16'sd1;
                    endcase
                end
                else
                    v = SAMPLE_W'($urandom);
                if ($urandom_range(99) < 80)
                    idx = TAP_INDEX_W'($urandom_range(0, eff - 1));
                else
                    idx = TAP_INDEX_W'($urandom_range(0, MAX_TAPS - 1));
                send_request(is_tap ? CMD_LOAD_TAP : CMD_SAMPLE, idx, v, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result checking and receiver back-pressure
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("filtered_sample: expected none, actual %0d", filtered_sample);
                error_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (filtered_sample !== want)
                begin
                    $error("filtered_sample: expected %0d, actual %0d", want, filtered_sample);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/fcf_pkg.sv
rtl/fcf_ram.sv
rtl/fcf_ctrl.sv
rtl/fcf_datapath.sv
rtl/fir_convolution_filter_top.sv
tb/fir_convolution_filter_top_tb.sv
